/* hw/rtl/msp_pkg.sv */
// Shared constants, types and widths for the servo pulse generator.
`timescale 1ns / 1ps

package msp_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int PERIOD_TICKS = 2000;
   localparam int COUNT_WIDTH  = $clog2(PERIOD_TICKS + 1);

   localparam int CMD_WIDTH    = 2;
   localparam int CHAN_WIDTH   = 2;
   localparam int VALUE_WIDTH  = 16;
   localparam int TICKS_WIDTH  = 9;
   localparam int ANGLE_WIDTH  = 8;

   localparam logic [TICKS_WIDTH-1:0] CENTER_TICKS = 9'd150;
   localparam logic [TICKS_WIDTH-1:0] MIN_TICKS    = 9'd50;
   localparam logic [TICKS_WIDTH-1:0] MAX_TICKS    = 9'd300;

   localparam logic [11:0] MIN_US    = 12'd500;
   localparam logic [11:0] MAX_US    = 12'd3000;
   localparam logic [11:0] ROUND_US  = 12'd5;
   localparam logic [7:0]  MAX_ANGLE = 8'd180;
   localparam logic [9:0]  MAX_ADC   = 10'd1023;

   // reciprocal constants: floor(n / d) == (n * R) >> s over the ranges used
   localparam logic [12:0] US_RECIP    = 13'd6554;    // d = 10,   s = 16
   localparam logic [11:0] ANGLE_RECIP = 12'd3641;    // d = 18,   s = 16
   localparam logic [19:0] ADC_RECIP   = 20'd524801;  // d = 2046, s = 30
   localparam logic [15:0] DEG_RECIP   = 16'd47186;   // 18 / 25,  s = 16

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK        = 2'd0,
      CMD_WRITE_US    = 2'd1,
      CMD_WRITE_ANGLE = 2'd2,
      CMD_WRITE_ADC   = 2'd3
   } command_type;

endpackage

/* hw/rtl/msp_stream_if.sv */
// Request and response stream interfaces of the servo pulse generator.
`timescale 1ns / 1ps

interface msp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [msp_pkg::CMD_WIDTH-1:0]        command;
   logic [msp_pkg::CHAN_WIDTH-1:0]       channel;
   logic [msp_pkg::VALUE_WIDTH-1:0]      value;

   modport source (output valid, command, channel, value, input ready);
   modport sink   (input valid, command, channel, value, output ready);
endinterface

interface msp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [msp_pkg::NUM_CHANNELS-1:0]     pin_levels;
   logic                                 period_start;
   logic [msp_pkg::TICKS_WIDTH-1:0]      pulse_ticks;
   logic [msp_pkg::ANGLE_WIDTH-1:0]      angle;

   modport source (output valid, pin_levels, period_start, pulse_ticks, angle, input ready);
   modport sink   (input valid, pin_levels, period_start, pulse_ticks, angle, output ready);
endinterface

/* hw/rtl/multi_channel_servo_pwm.sv */
// A word accepted on req passes the three register stages in order to rsp.
// Throughput: one word per cycle unless rsp stalls; the stages (converted word,
// state update, angle/output register) advance independently under stall.
// Reset (synchronous): counter 0, pins low, all widths 150 ticks, enables 0.
// No clearing pass: counter, pins, widths and enables sit in flip-flops cleared by reset.
`timescale 1ns / 1ps

module multi_channel_servo_pwm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [msp_pkg::NUM_CHANNELS-1:0]  csr_write_data,
   msp_req_if.sink                           req,
   msp_rsp_if.source                         rsp
);

   localparam int NC = msp_pkg::NUM_CHANNELS;
   localparam int CW = msp_pkg::COUNT_WIDTH;
   localparam int TW = msp_pkg::TICKS_WIDTH;

   // stage handshake
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, s2_free, s1_free, s2_load, req_accept;

   // stage 1: converted word
   msp_pkg::command_type           s1_cmd_ff, s1_cmd_in;
   logic [msp_pkg::CHAN_WIDTH-1:0] s1_ch_ff, s1_ch_in;
   logic [TW-1:0]                  s1_ticks_ff, s1_ticks_in;

   // stage 2: result after state update
   logic [NC-1:0] s2_pins_ff, s2_pins_in;
   logic          s2_start_ff, s2_start_in;
   logic [TW-1:0] s2_ticks_ff, s2_ticks_in;

   // output register
   logic [NC-1:0]                   out_pins_ff, out_pins_in;
   logic                            out_start_ff, out_start_in;
   logic [TW-1:0]                   out_ticks_ff, out_ticks_in;
   logic [msp_pkg::ANGLE_WIDTH-1:0] out_angle_ff, out_angle_in;

   // block state
   logic [CW-1:0] count_ff, count_in;
   logic [NC-1:0] pins_ff, pins_in;
   logic [NC-1:0] enable_ff, enable_in;
   logic [TW-1:0] width_ff [NC];
   logic [TW-1:0] width_in [NC];

   // conversion intermediates
   logic [11:0] us_clamp, us_round;
   logic [24:0] us_prod;
   logic [7:0]  ang_clamp;
   logic [12:0] ang_num;
   logic [24:0] ang_prod;
   logic [9:0]  adc_clamp;
   logic [18:0] adc_num;
   logic [38:0] adc_prod;

   // state update intermediates
   logic [CW-1:0] count_step;
   logic [CW-1:0] count_item;
   logic [NC-1:0] pins_item;
   logic [TW-1:0] width_item [NC];
   logic          start_item;
   logic          ch_ok;
   logic [NC-1:0] rising;

   // angle intermediates
   logic [TW-1:0] deg_clamp;
   logic [7:0]    deg_offset;
   logic [23:0]   deg_prod;

   // handshake
   assign out_free   = !out_valid_ff || rsp.ready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign s2_load    = s1_valid_ff && s2_free;
   assign req_accept = req.valid && s1_free;
   assign req.ready  = s1_free;

   always_comb begin
      s1_valid_in  = s1_free ? req.valid : s1_valid_ff;
      s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_free ? s2_valid_ff : out_valid_ff;
   end

   // stage 1: turn the value into ticks for each write source
   always_comb begin
      if (req.value < 16'(msp_pkg::MIN_US)) begin
         us_clamp = msp_pkg::MIN_US;
      end else if (req.value > 16'(msp_pkg::MAX_US)) begin
         us_clamp = msp_pkg::MAX_US;
      end else begin
         us_clamp = req.value[11:0];
      end
      us_round = us_clamp + msp_pkg::ROUND_US;
      us_prod  = 25'(us_round) * 25'(msp_pkg::US_RECIP);

      // ticks = 50 + (25a + 9) / 18
      ang_clamp = (req.value > 16'(msp_pkg::MAX_ANGLE)) ? msp_pkg::MAX_ANGLE : req.value[7:0];
      ang_num   = 13'(ang_clamp) * 13'd25 + 13'd9;
      ang_prod  = 25'(ang_num) * 25'(msp_pkg::ANGLE_RECIP);

      // ticks = 50 + (500v + 1023) / 2046
      adc_clamp = (req.value > 16'(msp_pkg::MAX_ADC)) ? msp_pkg::MAX_ADC : req.value[9:0];
      adc_num   = 19'(adc_clamp) * 19'd500 + 19'd1023;
      adc_prod  = 39'(adc_num) * 39'(msp_pkg::ADC_RECIP);

      s1_cmd_in = msp_pkg::command_type'(req.command);
      s1_ch_in  = req.channel;
      case (s1_cmd_in)
         msp_pkg::CMD_WRITE_US:    s1_ticks_in = us_prod[24:16];
         msp_pkg::CMD_WRITE_ANGLE: s1_ticks_in = msp_pkg::MIN_TICKS + ang_prod[24:16];
         msp_pkg::CMD_WRITE_ADC:   s1_ticks_in = msp_pkg::MIN_TICKS + adc_prod[38:30];
         default:                  s1_ticks_in = msp_pkg::CENTER_TICKS;
      endcase
   end

   // stage 2: apply the word to the counter, pins and widths
   always_comb begin
      ch_ok      = 32'(s1_ch_ff) < NC;
      count_step = count_ff + 1'b1;
      count_item = count_ff;
      pins_item  = pins_ff;
      start_item = 1'b0;
      for (int c = 0; c < NC; c++) begin
         width_item[c] = width_ff[c];
      end

      if (s1_cmd_ff == msp_pkg::CMD_TICK) begin
         count_item = count_step;
         if (32'(count_step) >= msp_pkg::PERIOD_TICKS) begin
            count_item = '0;
            start_item = 1'b1;
            pins_item  = pins_ff | enable_ff;
         end
         for (int c = 0; c < NC; c++) begin
            if (enable_ff[c] && (32'(count_item) == 32'(width_ff[c]))) begin
               pins_item[c] = 1'b0;
            end
         end
      end else if (ch_ok) begin
         width_item[s1_ch_ff] = s1_ticks_ff;
      end

      s2_pins_in  = pins_item;
      s2_start_in = start_item;
      s2_ticks_in = ch_ok ? width_item[s1_ch_ff] : '0;

      // newly enabled channels restart at centre with the pin low
      rising    = csr_write_data & ~enable_ff;
      enable_in = enable_ff;
      count_in  = count_ff;
      pins_in   = pins_ff;
      for (int c = 0; c < NC; c++) begin
         width_in[c] = width_ff[c];
      end
      if (csr_write_enable) begin
         enable_in = csr_write_data;
         pins_in   = pins_ff & csr_write_data & ~rising;
         for (int c = 0; c < NC; c++) begin
            if (rising[c]) begin
               width_in[c] = msp_pkg::CENTER_TICKS;
            end
         end
      end else if (s2_load) begin
         count_in = count_item;
         pins_in  = pins_item;
         for (int c = 0; c < NC; c++) begin
            width_in[c] = width_item[c];
         end
      end
   end

   // output stage: angle = (clamp(ticks) - 50) * 18 / 25
   always_comb begin
      if (s2_ticks_ff < msp_pkg::MIN_TICKS) begin
         deg_clamp = msp_pkg::MIN_TICKS;
      end else if (s2_ticks_ff > msp_pkg::MAX_TICKS) begin
         deg_clamp = msp_pkg::MAX_TICKS;
      end else begin
         deg_clamp = s2_ticks_ff;
      end
      deg_offset   = 8'(deg_clamp - msp_pkg::MIN_TICKS);
      deg_prod     = 24'(deg_offset) * 24'(msp_pkg::DEG_RECIP);
      out_pins_in  = s2_pins_ff;
      out_start_in = s2_start_ff;
      out_ticks_in = s2_ticks_ff;
      out_angle_in = deg_prod[23:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         pins_ff      <= '0;
         enable_ff    <= '0;
         for (int c = 0; c < NC; c++) begin
            width_ff[c] <= msp_pkg::CENTER_TICKS;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         pins_ff      <= pins_in;
         enable_ff    <= enable_in;
         for (int c = 0; c < NC; c++) begin
            width_ff[c] <= width_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff   <= s1_cmd_in;
         s1_ch_ff    <= s1_ch_in;
         s1_ticks_ff <= s1_ticks_in;
      end
      if (s2_load) begin
         s2_pins_ff  <= s2_pins_in;
         s2_start_ff <= s2_start_in;
         s2_ticks_ff <= s2_ticks_in;
      end
      if (out_free && s2_valid_ff) begin
         out_pins_ff  <= out_pins_in;
         out_start_ff <= out_start_in;
         out_ticks_ff <= out_ticks_in;
         out_angle_ff <= out_angle_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.pin_levels   = out_pins_ff;
   assign rsp.period_start = out_start_ff;
   assign rsp.pulse_ticks  = out_ticks_ff;
   assign rsp.angle        = out_angle_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) < msp_pkg::PERIOD_TICKS)
      else $error("period counter out of range");

   a_disabled_low: assert property (@(posedge clock) disable iff (reset)
      (pins_ff & ~enable_ff) == '0)
      else $error("disabled channel pin driven high");

   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      s2_load && !csr_write_enable && s2_start_in |=> count_ff == '0)
      else $error("period start without counter wrap");

   a_ticks_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.pulse_ticks >= msp_pkg::MIN_TICKS
                     && rsp.pulse_ticks <= msp_pkg::MAX_TICKS))
      else $error("pulse width outside servo range");

endmodule

/* bench/multi_channel_servo_pwm_test.sv */
// Self-checking testbench for the four-channel servo pulse generator.
`timescale 1ns / 1ps

module multi_channel_servo_pwm_test;
   import msp_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_STEPS = 28;

   typedef logic [NUM_CHANNELS-1:0] channel_mask_type;

   typedef struct packed {
      channel_mask_type         pins;
      logic                     start;
      logic [TICKS_WIDTH-1:0]   ticks;
      logic [ANGLE_WIDTH-1:0]   angle;
   } servo_reading_type;

   class servo_scoreboard;
      channel_mask_type         enable_mask;
      int unsigned              period_count;
      logic [TICKS_WIDTH-1:0]   width_ticks [NUM_CHANNELS];
      channel_mask_type         pin_state;
      servo_reading_type        expected_q [$];
      int unsigned              mismatch_count;
      int unsigned              checked_count;

      function new();
         enable_mask = '0;
         period_count = 0;
         pin_state = '0;
         mismatch_count = 0;
         checked_count = 0;
         foreach (width_ticks[c]) width_ticks[c] = CENTER_TICKS;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function int unsigned ticks_from_us(int unsigned us);
         if (us < MIN_US) us = MIN_US;
         if (us > MAX_US) us = MAX_US;
         return (us + ROUND_US) / 10;
      endfunction

      function int unsigned angle_from_ticks(int unsigned ticks);
         int unsigned us;
         us = ticks * 10;
         if (us < MIN_US) us = MIN_US;
         if (us > MAX_US) us = MAX_US;
         return ((us - MIN_US) * MAX_ANGLE) / (MAX_US - MIN_US);
      endfunction

      // a newly enabled channel restarts at centre with its pin low
      function void apply_enable(channel_mask_type mask);
         channel_mask_type rising;
         rising = mask & ~enable_mask;
         for (int c = 0; c < NUM_CHANNELS; c++)
            if (rising[c]) width_ticks[c] = CENTER_TICKS;
         pin_state &= mask & ~rising;
         enable_mask = mask;
      endfunction

      function void note_request(command_type cmd, logic [CHAN_WIDTH-1:0] ch,
                                 logic [VALUE_WIDTH-1:0] val);
         servo_reading_type want;
         int unsigned  us;
         int unsigned  level;
         want.start = 1'b0;
         level = 32'(val);
         if (cmd == CMD_TICK) begin
            period_count++;
            if (period_count >= PERIOD_TICKS) begin
               period_count = 0;
               want.start = 1'b1;
               pin_state |= enable_mask;
            end
            for (int c = 0; c < NUM_CHANNELS; c++)
               if (enable_mask[c] && period_count == width_ticks[c]) pin_state[c] = 1'b0;
         end else begin
            case (cmd)
               CMD_WRITE_US: us = level;
               CMD_WRITE_ANGLE: begin
                  if (level > MAX_ANGLE) level = MAX_ANGLE;
                  us = MIN_US + (level * (MAX_US - MIN_US)) / MAX_ANGLE;
               end
               default: begin
                  if (level > MAX_ADC) level = MAX_ADC;
                  us = MIN_US + (level * (MAX_US - MIN_US)) / MAX_ADC;
               end
            endcase
            width_ticks[ch] = TICKS_WIDTH'(ticks_from_us(us));
         end
         want.pins = pin_state;
         want.ticks = width_ticks[ch];
         want.angle = ANGLE_WIDTH'(angle_from_ticks(32'(width_ticks[ch])));
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string what, int got, int want);
         mismatch_count++;
         $display("mismatch on word %0d: %s got %0d want %0d",
                  checked_count, what, got, want);
      endtask

      task check_response(channel_mask_type pins, logic start,
                          logic [TICKS_WIDTH-1:0] ticks, logic [ANGLE_WIDTH-1:0] ang);
         servo_reading_type want;
         checked_count++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected word, pin_levels", 32'(pins), 0);
         end else begin
            want = expected_q.pop_front();
            if (pins !== want.pins)
               report_mismatch("pin_levels", 32'(pins), 32'(want.pins));
            if (start !== want.start)
               report_mismatch("period_start", 32'(start), 32'(want.start));
            if (ticks !== want.ticks)
               report_mismatch("pulse_ticks", 32'(ticks), 32'(want.ticks));
            if (ang !== want.angle)
               report_mismatch("angle", 32'(ang), 32'(want.angle));
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   channel_mask_type         csr_write_data;
   logic                     steady;
   logic                     stall_wanted;
   servo_scoreboard          board;

   msp_req_if req_bus ();
   msp_rsp_if rsp_bus ();

   multi_channel_servo_pwm u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_bus),
      .rsp              (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // offer one word at a falling edge, hold it until accepted
   task automatic send_word(command_type cmd, logic [CHAN_WIDTH-1:0] ch,
                            logic [VALUE_WIDTH-1:0] val);
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.channel <= ch;
      req_bus.value <= val;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_request(cmd, ch, val);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_enable(channel_mask_type mask);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= mask;
      @(posedge clock);
      board.apply_enable(mask);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_value(command_type cmd);
      if ($urandom_range(0, 4) == 0) return VALUE_WIDTH'($urandom_range(0, 65535));
      case (cmd)
         CMD_WRITE_US:    return VALUE_WIDTH'($urandom_range(400, 3100));
         CMD_WRITE_ANGLE: return VALUE_WIDTH'($urandom_range(0, 190));
         default:         return VALUE_WIDTH'($urandom_range(0, 1040));
      endcase
   endfunction

   task automatic send_random_write();
      command_type cmd;
      cmd = command_type'($urandom_range(1, 3));
      send_word(cmd, CHAN_WIDTH'($urandom_range(0, 3)), pick_value(cmd));
   endtask

   task automatic send_ticks(int unsigned count);
      repeat (count)
         send_word(CMD_TICK, CHAN_WIDTH'($urandom_range(0, 3)),
                   VALUE_WIDTH'($urandom_range(0, 65535)));
   endtask

   initial begin : response_sink
      int unsigned hold;
      @(negedge clock);
      forever begin
         if (stall_wanted) begin
            stall_wanted = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clock);
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 21);
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            board.check_response(rsp_bus.pin_levels, rsp_bus.period_start,
                                 rsp_bus.pulse_ticks, rsp_bus.angle);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      channel_mask_type phase_masks [6];
      int unsigned steps;
      board = new();
      reset = 1'b1;
      steady = 1'b0;
      stall_wanted = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_TICK;
      req_bus.channel = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // width is kept on a disabled channel, then recentred when it is enabled
      send_word(CMD_WRITE_US, 2'd2, 16'd2000);
      send_word(CMD_TICK, 2'd2, 16'd0);
      write_enable(4'hF);
      send_word(CMD_TICK, 2'd2, 16'hFFFF);
      send_word(CMD_WRITE_US, 2'd0, 16'd0);
      send_word(CMD_WRITE_US, 2'd1, 16'd499);
      send_word(CMD_WRITE_US, 2'd2, 16'd500);
      send_word(CMD_WRITE_US, 2'd3, 16'd3000);
      send_word(CMD_WRITE_US, 2'd0, 16'd3001);
      send_word(CMD_WRITE_US, 2'd1, 16'hFFFF);
      send_word(CMD_WRITE_US, 2'd2, 16'd1504);
      send_word(CMD_WRITE_US, 2'd3, 16'd1505);
      send_word(CMD_WRITE_ANGLE, 2'd0, 16'd0);
      send_word(CMD_WRITE_ANGLE, 2'd1, 16'd180);
      send_word(CMD_WRITE_ANGLE, 2'd2, 16'd181);
      send_word(CMD_WRITE_ANGLE, 2'd3, 16'hFFFF);
      send_word(CMD_WRITE_ANGLE, 2'd0, 16'd90);
      send_word(CMD_WRITE_ADC, 2'd1, 16'd0);
      send_word(CMD_WRITE_ADC, 2'd2, 16'd1023);
      send_word(CMD_WRITE_ADC, 2'd3, 16'd1024);
      send_word(CMD_WRITE_ADC, 2'd0, 16'hFFFF);
      send_word(CMD_WRITE_ADC, 2'd1, 16'd511);
      send_word(CMD_TICK, 2'd3, 16'd0);
      write_enable(4'h3);
      send_word(CMD_WRITE_US, 2'd3, 16'd2600);
      send_word(CMD_TICK, 2'd3, 16'd0);
      send_word(CMD_TICK, 2'd0, 16'd0);

      phase_masks[0] = 4'h5;
      phase_masks[1] = 4'hF;
      phase_masks[2] = 4'h0;
      phase_masks[3] = 4'hA;
      phase_masks[4] = 4'hF;
      phase_masks[5] = channel_mask_type'($urandom_range(0, 15));
      for (int phase = 0; phase < 6; phase++) begin
         write_enable(phase_masks[phase]);
         steady = (phase == 3);
         // hold the sink off early in this phase so the pipeline backs up
         if (phase == 1) stall_wanted = 1'b1;
         steps = 0;
         while (steps < PHASE_STEPS) begin
            if ($urandom_range(0, 3) == 0) send_random_write();
            else send_ticks($urandom_range(1, 8));
            steps++;
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (10) @(negedge clock);
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
